FILE: src/npg_pkg.sv
// ----------------------------------------------------------------------------
// npg_pkg
// Shared constants, types and helpers for the nearest-prototype grid
// classifier: field widths, internal arithmetic widths and tree node type.
// ----------------------------------------------------------------------------
package npg_pkg;

  localparam int MAX_PROTOTYPES = 16;
  localparam int COORD_BITS     = 32;

  localparam int DATA_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int ACT_W      = 5;
  localparam int EIDX_W     = 4;
  localparam int CLASS_W    = 8;
  localparam int GRID_W     = 12;

  localparam int IDX_W       = (MAX_PROTOTYPES > 1) ? $clog2(MAX_PROTOTYPES) : 1;
  localparam int TREE_LEVELS = $clog2(MAX_PROTOTYPES);
  localparam int TREE_LANES  = 1 << TREE_LEVELS;

  // Arithmetic widths: grid index times step, cell centre, difference,
  // square halves, square and summed distance. All exact.
  localparam int PROD_W = COORD_BITS + GRID_W + 1;
  localparam int CTR_W  = PROD_W + 1;
  localparam int DIFF_W = CTR_W + 1;
  localparam int LO_W   = DIFF_W / 2;
  localparam int HI_W   = DIFF_W - LO_W;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int DIST_W = SQ_W + 1;

  localparam int STEP_RESET   = 65536;
  localparam int ACTIVE_RESET = 1;

  typedef enum logic {
    FUNC_LOAD     = 1'b0,
    FUNC_CLASSIFY = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_ORIGIN = 3'd0,
    CFG_X_STEP   = 3'd1,
    CFG_Y_ORIGIN = 3'd2,
    CFG_Y_STEP   = 3'd3,
    CFG_ACTIVE   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_origin;
    logic signed [COORD_BITS-1:0] x_step;
    logic signed [COORD_BITS-1:0] y_origin;
    logic signed [COORD_BITS-1:0] y_step;
  } grid_cfg_t;

  typedef struct packed {
    logic                act;
    logic [DIST_W-1:0]   sq_dist;
    logic [IDX_W-1:0]    idx;
    logic [CLASS_W-1:0]  cls;
  } node_t;

  // Right side wins only when strictly closer: lower index keeps ties.
  function automatic node_t pick(input node_t lft, input node_t rgt);
    node_t res;
    if (rgt.act && (!lft.act || (rgt.sq_dist < lft.sq_dist))) begin
      res = rgt;
    end else begin
      res = lft;
    end
    return res;
  endfunction

endpackage

FILE: src/npg_front.sv
// ----------------------------------------------------------------------------
// npg_front
// Input stage and cell-centre stage. Multiplies grid indexes by the steps,
// adds the origins, and holds the prototype table written by load items.
// ----------------------------------------------------------------------------
module npg_front (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      en,
  input  npg_pkg::grid_cfg_t                        cfg,
  input  logic                                      in_valid,
  input  logic                                      in_func,
  input  logic [npg_pkg::EIDX_W-1:0]                in_entry_index,
  input  logic [npg_pkg::DATA_W-1:0]                in_entry_x,
  input  logic [npg_pkg::DATA_W-1:0]                in_entry_y,
  input  logic [npg_pkg::CLASS_W-1:0]               in_entry_class,
  input  logic [npg_pkg::GRID_W-1:0]                in_cell_row,
  input  logic [npg_pkg::GRID_W-1:0]                in_cell_col,
  output logic                                      ctr_valid,
  output logic signed [npg_pkg::CTR_W-1:0]          ctr_x,
  output logic signed [npg_pkg::CTR_W-1:0]          ctr_y,
  output logic signed [npg_pkg::COORD_BITS-1:0]     tab_x   [npg_pkg::MAX_PROTOTYPES],
  output logic signed [npg_pkg::COORD_BITS-1:0]     tab_y   [npg_pkg::MAX_PROTOTYPES],
  output logic [npg_pkg::CLASS_W-1:0]               tab_cls [npg_pkg::MAX_PROTOTYPES]
);

  localparam int CB = npg_pkg::COORD_BITS;
  localparam int PW = npg_pkg::PROD_W;
  localparam int CW = npg_pkg::CTR_W;

  logic                              s1_valid_r;
  npg_pkg::func_t                    s1_func_r;
  logic [npg_pkg::IDX_W-1:0]         s1_idx_r;
  logic                              s1_idx_ok_r;
  logic signed [CB-1:0]              s1_x_r;
  logic signed [CB-1:0]              s1_y_r;
  logic [npg_pkg::CLASS_W-1:0]       s1_cls_r;
  logic signed [PW-1:0]              s1_mx_r;
  logic signed [PW-1:0]              s1_my_r;

  logic signed [PW-1:0]              col_ext, row_ext, xstep_ext, ystep_ext;
  logic signed [PW-1:0]              mx_nxt, my_nxt;
  logic                              idx_ok_nxt;
  logic signed [CW-1:0]              cx_nxt, cy_nxt;

  logic                              ctr_valid_r;
  logic signed [CW-1:0]              ctr_x_r, ctr_y_r;

  logic signed [CB-1:0]              tab_x_r   [npg_pkg::MAX_PROTOTYPES];
  logic signed [CB-1:0]              tab_y_r   [npg_pkg::MAX_PROTOTYPES];
  logic [npg_pkg::CLASS_W-1:0]       tab_cls_r [npg_pkg::MAX_PROTOTYPES];

  always_comb begin
    col_ext    = {{(PW-npg_pkg::GRID_W){1'b0}}, in_cell_col};
    row_ext    = {{(PW-npg_pkg::GRID_W){1'b0}}, in_cell_row};
    xstep_ext  = {{(PW-CB){cfg.x_step[CB-1]}}, cfg.x_step};
    ystep_ext  = {{(PW-CB){cfg.y_step[CB-1]}}, cfg.y_step};
    mx_nxt     = col_ext * xstep_ext;
    my_nxt     = row_ext * ystep_ext;
    idx_ok_nxt = (32'(in_entry_index) < 32'(npg_pkg::MAX_PROTOTYPES));
    cx_nxt     = {{(CW-CB){cfg.x_origin[CB-1]}}, cfg.x_origin} + {s1_mx_r[PW-1], s1_mx_r};
    cy_nxt     = {{(CW-CB){cfg.y_origin[CB-1]}}, cfg.y_origin} + {s1_my_r[PW-1], s1_my_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      ctr_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= in_valid;
      ctr_valid_r <= s1_valid_r && (s1_func_r == npg_pkg::FUNC_CLASSIFY);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_func_r   <= npg_pkg::func_t'(in_func);
      s1_idx_r    <= npg_pkg::IDX_W'(in_entry_index);
      s1_idx_ok_r <= idx_ok_nxt;
      s1_x_r      <= in_entry_x[CB-1:0];
      s1_y_r      <= in_entry_y[CB-1:0];
      s1_cls_r    <= in_entry_class;
      s1_mx_r     <= mx_nxt;
      s1_my_r     <= my_nxt;
      ctr_x_r     <= cx_nxt;
      ctr_y_r     <= cy_nxt;
    end
  end

  // Write the table as a load leaves the first stage, so a classify item
  // reads exactly the loads that came before it.
  always_ff @(posedge clk) begin
    if (en && s1_valid_r && (s1_func_r == npg_pkg::FUNC_LOAD) && s1_idx_ok_r) begin
      tab_x_r[s1_idx_r]   <= s1_x_r;
      tab_y_r[s1_idx_r]   <= s1_y_r;
      tab_cls_r[s1_idx_r] <= s1_cls_r;
    end
  end

  assign ctr_valid = ctr_valid_r;
  assign ctr_x     = ctr_x_r;
  assign ctr_y     = ctr_y_r;
  assign tab_x     = tab_x_r;
  assign tab_y     = tab_y_r;
  assign tab_cls   = tab_cls_r;

endmodule

FILE: src/npg_dist.sv
// ----------------------------------------------------------------------------
// npg_dist
// One lane per prototype: difference, magnitude, split-half squares,
// square assembly and x plus y sum, one register stage each.
// ----------------------------------------------------------------------------
module npg_dist (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    en,
  input  logic                                    ctr_valid,
  input  logic signed [npg_pkg::CTR_W-1:0]        ctr_x,
  input  logic signed [npg_pkg::CTR_W-1:0]        ctr_y,
  input  logic signed [npg_pkg::COORD_BITS-1:0]   tab_x   [npg_pkg::MAX_PROTOTYPES],
  input  logic signed [npg_pkg::COORD_BITS-1:0]   tab_y   [npg_pkg::MAX_PROTOTYPES],
  input  logic [npg_pkg::CLASS_W-1:0]             tab_cls [npg_pkg::MAX_PROTOTYPES],
  output logic                                    dist_valid,
  output logic [npg_pkg::DIST_W-1:0]              lane_dist [npg_pkg::MAX_PROTOTYPES],
  output logic [npg_pkg::CLASS_W-1:0]             dist_cls[npg_pkg::MAX_PROTOTYPES]
);

  localparam int CB  = npg_pkg::COORD_BITS;
  localparam int CW  = npg_pkg::CTR_W;
  localparam int DW  = npg_pkg::DIFF_W;
  localparam int LW  = npg_pkg::LO_W;
  localparam int HW  = npg_pkg::HI_W;
  localparam int SW  = npg_pkg::SQ_W;
  localparam int TW  = npg_pkg::DIST_W;
  localparam int NST = 5;

  logic [NST-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], ctr_valid};
    end
  end

  assign dist_valid = vld_r[NST-1];

  for (genvar i = 0; i < npg_pkg::MAX_PROTOTYPES; i++) begin : g_lane
    logic signed [DW-1:0]          dx_r, dy_r;
    logic [DW-1:0]                 ax_r, ay_r;
    logic [2*HW-1:0]               xhh_r, yhh_r;
    logic [HW+LW-1:0]              xhl_r, yhl_r;
    logic [2*LW-1:0]               xll_r, yll_r;
    logic [SW-1:0]                 sqx_r, sqy_r;
    logic [TW-1:0]                 dist_r;
    logic [npg_pkg::CLASS_W-1:0]   cls_r [NST];

    always_ff @(posedge clk) begin
      if (en) begin
        dx_r   <= {ctr_x[CW-1], ctr_x} - {{(DW-CB){tab_x[i][CB-1]}}, tab_x[i]};
        dy_r   <= {ctr_y[CW-1], ctr_y} - {{(DW-CB){tab_y[i][CB-1]}}, tab_y[i]};
        ax_r   <= dx_r[DW-1] ? DW'(-dx_r) : DW'(dx_r);
        ay_r   <= dy_r[DW-1] ? DW'(-dy_r) : DW'(dy_r);
        xhh_r  <= (2*HW)'(ax_r[DW-1:LW]) * (2*HW)'(ax_r[DW-1:LW]);
        xhl_r  <= (HW+LW)'(ax_r[DW-1:LW]) * (HW+LW)'(ax_r[LW-1:0]);
        xll_r  <= (2*LW)'(ax_r[LW-1:0]) * (2*LW)'(ax_r[LW-1:0]);
        yhh_r  <= (2*HW)'(ay_r[DW-1:LW]) * (2*HW)'(ay_r[DW-1:LW]);
        yhl_r  <= (HW+LW)'(ay_r[DW-1:LW]) * (HW+LW)'(ay_r[LW-1:0]);
        yll_r  <= (2*LW)'(ay_r[LW-1:0]) * (2*LW)'(ay_r[LW-1:0]);
        // (h*2^L + l)^2 = h*h*2^2L + 2*h*l*2^L + l*l
        sqx_r  <= (SW'(xhh_r) << (2*LW)) + (SW'(xhl_r) << (LW+1)) + SW'(xll_r);
        sqy_r  <= (SW'(yhh_r) << (2*LW)) + (SW'(yhl_r) << (LW+1)) + SW'(yll_r);
        dist_r <= TW'(sqx_r) + TW'(sqy_r);
        cls_r[0] <= tab_cls[i];
        for (int s = 1; s < NST; s++) begin
          cls_r[s] <= cls_r[s-1];
        end
      end
    end

    assign lane_dist[i] = dist_r;
    assign dist_cls[i]  = cls_r[NST-1];
  end

endmodule

FILE: src/npg_tree.sv
// ----------------------------------------------------------------------------
// npg_tree
// Registered minimum tree over the lane distances, one level per stage.
// Lower index wins on equal distance; inactive lanes never win.
// ----------------------------------------------------------------------------
module npg_tree (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          lane_valid,
  input  logic [npg_pkg::DIST_W-1:0]    lane_dist [npg_pkg::MAX_PROTOTYPES],
  input  logic [npg_pkg::CLASS_W-1:0]   dist_cls [npg_pkg::MAX_PROTOTYPES],
  input  logic [npg_pkg::MAX_PROTOTYPES-1:0] lane_act,
  output logic                          root_valid,
  output npg_pkg::node_t                root
);

  localparam int NL = npg_pkg::TREE_LANES;
  localparam int LV = npg_pkg::TREE_LEVELS;

  npg_pkg::node_t leaf [NL];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      leaf[i] = '0;
      if (i < npg_pkg::MAX_PROTOTYPES) begin
        leaf[i].act     = lane_act[i];
        leaf[i].sq_dist = lane_dist[i];
        leaf[i].idx     = npg_pkg::IDX_W'(i);
        leaf[i].cls     = dist_cls[i];
      end
    end
  end

  if (LV == 0) begin : g_single
    assign root_valid = lane_valid;
    assign root       = leaf[0];
  end else begin : g_tree
    logic [LV-1:0]  vld_r;
    npg_pkg::node_t node_r [1:NL-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= '0;
      end else if (en) begin
        vld_r[0] <= lane_valid;
        for (int j = 1; j < LV; j++) begin
          vld_r[j] <= vld_r[j-1];
        end
      end
    end

    // Heap order: node k has children 2k and 2k+1; the bottom row reads leaves.
    for (genvar k = 1; k < NL; k++) begin : g_node
      npg_pkg::node_t lc, rc;
      if (2 * k >= NL) begin : g_bottom
        assign lc = leaf[2*k-NL];
        assign rc = leaf[2*k+1-NL];
      end else begin : g_inner
        assign lc = node_r[2*k];
        assign rc = node_r[2*k+1];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          node_r[k] <= npg_pkg::pick(lc, rc);
        end
      end
    end

    assign root_valid = vld_r[LV-1];
    assign root       = node_r[1];
  end

endmodule

FILE: src/nearest_prototype_grid_classifier_top.sv
// ----------------------------------------------------------------------------
// nearest_prototype_grid_classifier_top
// Nearest-prototype classifier over a 2-D grid of cells.
//
// Channels: in_* carries one item per valid/ready handshake. A load item
// (in_func = load) writes one prototype entry and gives no result. A
// classify item names a grid cell by row and column; its result (label and
// table index of the nearest prototype, lowest index on ties) leaves on
// out_* under valid/ready. cfg_* writes the grid origin, steps and the
// active entry count; write it only while no item is in flight.
// Pipeline: a classify result reaches out_valid through two front stages
// (index times step, centre), five lane stages (difference, magnitude,
// half products, square, sum), four compare-tree levels and the output
// register. Throughput: one item per cycle unless the output stalls.
// Reset clears all valid bits and restores the register defaults; the
// prototype table holds whatever it held until loaded. When the receiver
// holds out_ready low with a result waiting, the whole pipeline freezes and
// in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module nearest_prototype_grid_classifier_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [npg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [npg_pkg::DATA_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic [npg_pkg::EIDX_W-1:0]        in_entry_index,
  input  logic [npg_pkg::DATA_W-1:0]        in_entry_x,
  input  logic [npg_pkg::DATA_W-1:0]        in_entry_y,
  input  logic [npg_pkg::CLASS_W-1:0]       in_entry_class,
  input  logic [npg_pkg::GRID_W-1:0]        in_cell_row,
  input  logic [npg_pkg::GRID_W-1:0]        in_cell_col,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [npg_pkg::CLASS_W-1:0]       out_cell_class,
  output logic [npg_pkg::EIDX_W-1:0]        out_nearest_index
);

  localparam int CB = npg_pkg::COORD_BITS;
  localparam int NP = npg_pkg::MAX_PROTOTYPES;

  npg_pkg::grid_cfg_t               cfg_r;
  logic [npg_pkg::ACT_W-1:0]        active_r;
  logic [NP-1:0]                    lane_act;
  logic                             en;

  logic                             ctr_valid;
  logic signed [npg_pkg::CTR_W-1:0] ctr_x, ctr_y;
  logic signed [CB-1:0]             tab_x   [NP];
  logic signed [CB-1:0]             tab_y   [NP];
  logic [npg_pkg::CLASS_W-1:0]      tab_cls [NP];

  logic                             dist_valid;
  logic [npg_pkg::DIST_W-1:0]       lane_dist [NP];
  logic [npg_pkg::CLASS_W-1:0]      dist_cls [NP];

  logic                             root_valid;
  npg_pkg::node_t                   root;

  logic                             out_valid_r;
  logic [npg_pkg::CLASS_W-1:0]      out_cell_class_r;
  logic [npg_pkg::EIDX_W-1:0]       out_nearest_index_r;

  // Advance everything unless a result waits and is not taken.
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_origin <= '0;
      cfg_r.x_step   <= CB'(npg_pkg::STEP_RESET);
      cfg_r.y_origin <= '0;
      cfg_r.y_step   <= CB'(npg_pkg::STEP_RESET);
      active_r       <= npg_pkg::ACT_W'(npg_pkg::ACTIVE_RESET);
    end else if (cfg_we) begin
      case (npg_pkg::cfg_reg_t'(cfg_index))
        npg_pkg::CFG_X_ORIGIN: cfg_r.x_origin <= cfg_wdata[CB-1:0];
        npg_pkg::CFG_X_STEP:   cfg_r.x_step   <= cfg_wdata[CB-1:0];
        npg_pkg::CFG_Y_ORIGIN: cfg_r.y_origin <= cfg_wdata[CB-1:0];
        npg_pkg::CFG_Y_STEP:   cfg_r.y_step   <= cfg_wdata[CB-1:0];
        npg_pkg::CFG_ACTIVE:   active_r       <= cfg_wdata[npg_pkg::ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // Entry 0 always takes part; counts above the table size cover it all.
  always_comb begin
    for (int i = 0; i < NP; i++) begin
      lane_act[i] = (i == 0) || (32'(i) < 32'(active_r));
    end
  end

  npg_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_func        (in_func),
    .in_entry_index (in_entry_index),
    .in_entry_x     (in_entry_x),
    .in_entry_y     (in_entry_y),
    .in_entry_class (in_entry_class),
    .in_cell_row    (in_cell_row),
    .in_cell_col    (in_cell_col),
    .ctr_valid      (ctr_valid),
    .ctr_x          (ctr_x),
    .ctr_y          (ctr_y),
    .tab_x          (tab_x),
    .tab_y          (tab_y),
    .tab_cls        (tab_cls)
  );

  npg_dist u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .ctr_valid  (ctr_valid),
    .ctr_x      (ctr_x),
    .ctr_y      (ctr_y),
    .tab_x      (tab_x),
    .tab_y      (tab_y),
    .tab_cls    (tab_cls),
    .dist_valid (dist_valid),
    .lane_dist  (lane_dist),
    .dist_cls   (dist_cls)
  );

  npg_tree u_tree (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .lane_valid (dist_valid),
    .lane_dist  (lane_dist),
    .dist_cls   (dist_cls),
    .lane_act   (lane_act),
    .root_valid (root_valid),
    .root       (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= root_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cell_class_r    <= root.cls;
      out_nearest_index_r <= npg_pkg::EIDX_W'(root.idx);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cell_class    = out_cell_class_r;
  assign out_nearest_index = out_nearest_index_r;

endmodule
